FILE: design/lbmwb_pkg.sv
// Shared types, codes and small helpers for the D2Q9 wall boundary unit.
package lbmwb_pkg;

    localparam int NPOP       = 9;
    localparam int NLANE      = 3;
    localparam int LANE_A     = 0;
    localparam int LANE_N     = 1;
    localparam int LANE_B     = 2;
    localparam int NORM_W     = 2;
    localparam int OP_W       = 2;
    localparam int VEL_W      = 24;
    localparam int VEL_FRAC   = 20;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_BOUNCE = 2'd0,
        OP_MOVING = 2'd1,
        OP_ZOUHE  = 2'd2
    } op_t;

    typedef enum logic [CFG_ADDR_W-3:0] {
        REG_WALL_UX   = 2'd0,
        REG_WALL_UY   = 2'd1,
        REG_INFLOW_VX = 2'd2
    } cfg_reg_t;

    typedef logic [3:0] slot_t;

    localparam slot_t SLOT_C  = 4'd0;
    localparam slot_t SLOT_E  = 4'd1;
    localparam slot_t SLOT_W  = 4'd2;
    localparam slot_t SLOT_N  = 4'd3;
    localparam slot_t SLOT_S  = 4'd4;
    localparam slot_t SLOT_NE = 4'd5;
    localparam slot_t SLOT_NW = 4'd6;
    localparam slot_t SLOT_SE = 4'd7;
    localparam slot_t SLOT_SW = 4'd8;

    localparam logic signed [NORM_W-1:0] DIR_P   = 2'sb01;
    localparam logic signed [NORM_W-1:0] DIR_Z   = 2'sb00;
    localparam logic signed [NORM_W-1:0] DIR_M   = 2'sb11;
    localparam logic signed [NORM_W-1:0] DIR_BAD = 2'sb10;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
    } dir_t;

    function automatic dir_t neg_dir(input dir_t d);
        dir_t r;
        r.x = -d.x;
        r.y = -d.y;
        return r;
    endfunction

    function automatic slot_t slot_of(input dir_t d);
        slot_t s;
        case ({d.x, d.y})
            {DIR_Z, DIR_Z}: s = SLOT_C;
            {DIR_P, DIR_Z}: s = SLOT_E;
            {DIR_M, DIR_Z}: s = SLOT_W;
            {DIR_Z, DIR_P}: s = SLOT_N;
            {DIR_Z, DIR_M}: s = SLOT_S;
            {DIR_P, DIR_P}: s = SLOT_NE;
            {DIR_M, DIR_P}: s = SLOT_NW;
            {DIR_P, DIR_M}: s = SLOT_SE;
            {DIR_M, DIR_M}: s = SLOT_SW;
            default:        s = SLOT_C;
        endcase
        return s;
    endfunction

endpackage

FILE: design/lbm_d2q9_wall_boundary_unit.sv
// D2Q9 wall boundary unit: bounce-back, moving-wall and Zou-He correction of one cell.
//
// Each item is one boundary cell: an operation (tuser), a wall normal and nine
// populations (tdata). The wall normal and its two neighbours are rebuilt from
// their opposites by plain bounce-back, moving-wall bounce-back or Zou-He x
// velocity correction; the density is the east, centre and west populations
// plus twice the three opposites, saturated. A zero normal or the unused
// operation code passes the cell through. The unit is an 8-stage pipeline:
// it takes one item per clock while the output is not stalled, and the rho
// multiply and the divide-by-3 reciprocal multiply each have their own registered
// stages. Stalls back up stage by stage, and empty stages keep accepting while
// a result waits at the output register. Wall velocity and inflow velocity
// registers sit on the APB port at byte addresses 0, 4 and 8. The user must see
// that they are written only while the unit is idle; the unit does not enforce it.
module lbm_d2q9_wall_boundary_unit #(
    parameter int POP_WIDTH = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [lbmwb_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [lbmwb_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [lbmwb_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                   pready,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // normal_x, normal_y, f_center, f_east, f_west, f_north, f_south,
    // f_northeast, f_northwest, f_southeast, f_southwest, zero pad
    input  logic [((2*lbmwb_pkg::NORM_W + lbmwb_pkg::NPOP*POP_WIDTH + 7)/8)*8-1:0] s_tdata,
    // op
    input  logic [lbmwb_pkg::OP_W-1:0]             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // out_center, out_east, out_west, out_north, out_south,
    // out_northeast, out_northwest, out_southeast, out_southwest, zero pad
    output logic [((lbmwb_pkg::NPOP*POP_WIDTH + 7)/8)*8-1:0] m_tdata
);

    localparam int P        = POP_WIDTH;
    localparam int NPOP     = lbmwb_pkg::NPOP;
    localparam int NLANE    = lbmwb_pkg::NLANE;
    localparam int VEL_W    = lbmwb_pkg::VEL_W;
    localparam int VFRAC    = lbmwb_pkg::VEL_FRAC;
    localparam int CDW      = lbmwb_pkg::CFG_DATA_W;
    localparam int F_BASE   = 2*lbmwb_pkg::NORM_W;
    localparam int NSTG     = 8;
    localparam int ACC_W    = P + 2;        // sum of three populations
    localparam int RSW      = P + 4;        // raw density / saturation input
    localparam int VW       = VEL_W + 2;    // velocity dot product
    localparam int PW       = P + VW;       // rho times velocity
    localparam int NW       = PW + 2;       // moving-wall numerator
    localparam int IW       = PW + 1;       // Zou-He numerator
    localparam int XW       = P + 2;        // clamped quotient input
    localparam int HW       = (XW + 1)/2;
    localparam int HIW      = XW - HW;
    localparam int RCW      = P + 3;
    localparam int RECIP_SH = P + 4;
    localparam int PHW      = HIW + RCW;
    localparam int PLW      = HW + RCW;
    localparam int QW       = XW + RCW;
    localparam int MW       = P + 1;        // correction magnitude
    localparam int SW       = P + 3;        // final sum

    localparam logic [RCW-1:0] RECIP = RCW'(((64'd1 << RECIP_SH) + 64'd2) / 64'd3);
    localparam logic [NW-1:0]  RND1  = NW'(3 * (1 << VFRAC));
    localparam logic [IW-1:0]  RND2  = IW'(1 << VFRAC);
    localparam logic signed [RSW-1:0] SAT_HI = RSW'((64'sd1 <<< (P-1)) - 64'sd1);
    localparam logic signed [RSW-1:0] SAT_LO = -SAT_HI - RSW'(1);

    typedef logic signed [P-1:0] pop_t;

    typedef struct {
        lbmwb_pkg::op_t   op;
        logic             act;
        logic             zb;
        pop_t             f [NPOP];
        lbmwb_pkg::slot_t dst [NLANE];
        pop_t             v [NLANE];
        logic             diag [NLANE];
        logic signed [P:0] diff;
    } cr_t;

    typedef struct {
        cr_t                     cr;
        lbmwb_pkg::dir_t         src [NLANE];
        logic signed [ACC_W-1:0] ra;
        logic signed [ACC_W-1:0] rb;
    } s1_t;

    typedef struct {
        cr_t                  cr;
        pop_t                 rho;
        logic signed [VW-1:0] m [NLANE];
    } s2_t;

    typedef struct {
        cr_t                  cr;
        logic signed [PW-1:0] p [NLANE];
    } s3_t;

    typedef struct {
        cr_t                  cr;
        logic [NW-1:0]        n1sum [NLANE];
        logic                 n1neg [NLANE];
        logic signed [IW-1:0] inner [NLANE];
    } s4_t;

    typedef struct {
        cr_t           cr;
        logic [XW-1:0] x [NLANE];
        logic          n1neg [NLANE];
        logic [MW-1:0] m2 [NLANE];
        logic          in2neg [NLANE];
    } s5_t;

    typedef struct {
        cr_t            cr;
        logic [PHW-1:0] ph [NLANE];
        logic [PLW-1:0] pl [NLANE];
        logic           n1neg [NLANE];
        logic [MW-1:0]  m2 [NLANE];
        logic           in2neg [NLANE];
    } s6_t;

    typedef struct {
        cr_t           cr;
        logic [MW-1:0] mag [NLANE];
        logic          sub [NLANE];
    } s7_t;

    function automatic pop_t sat_pop(input logic signed [RSW-1:0] v);
        pop_t r;
        if (v > SAT_HI)
            r = SAT_HI[P-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[P-1:0];
        else
            r = v[P-1:0];
        return r;
    endfunction

    function automatic logic signed [VW-1:0] sel_vel(input logic signed [1:0] c,
                                                     input logic signed [VEL_W-1:0] u);
        logic signed [VW-1:0] r;
        case (c)
            lbmwb_pkg::DIR_P: r = VW'(u);
            lbmwb_pkg::DIR_M: r = -VW'(u);
            default:          r = '0;
        endcase
        return r;
    endfunction

    // configuration registers
    logic signed [VEL_W-1:0] ux_reg, ux_next;
    logic signed [VEL_W-1:0] uy_reg, uy_next;
    logic signed [VEL_W-1:0] vx_reg, vx_next;
    logic                    cfg_wr;

    // pipeline control and payload
    logic [NSTG:1] vld_reg, vld_next;
    logic [NSTG:1] en;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;
    s5_t  s5_reg, s5_next;
    s6_t  s6_reg, s6_next;
    s7_t  s7_reg, s7_next;
    pop_t out_reg [NPOP];
    pop_t out_next [NPOP];

    // input unpacking
    logic signed [1:0] nx_in, ny_in;
    pop_t              fin [NPOP];
    lbmwb_pkg::dir_t   dir_in [NLANE];

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        ux_next = ux_reg;
        uy_next = uy_reg;
        vx_next = vx_reg;
        if (cfg_wr)
        begin
            case (lbmwb_pkg::cfg_reg_t'(paddr[lbmwb_pkg::CFG_ADDR_W-1:2]))
                lbmwb_pkg::REG_WALL_UX:   ux_next = pwdata[VEL_W-1:0];
                lbmwb_pkg::REG_WALL_UY:   uy_next = pwdata[VEL_W-1:0];
                lbmwb_pkg::REG_INFLOW_VX: vx_next = pwdata[VEL_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (lbmwb_pkg::cfg_reg_t'(paddr[lbmwb_pkg::CFG_ADDR_W-1:2]))
            lbmwb_pkg::REG_WALL_UX:   prdata = {{(CDW-VEL_W){ux_reg[VEL_W-1]}}, ux_reg};
            lbmwb_pkg::REG_WALL_UY:   prdata = {{(CDW-VEL_W){uy_reg[VEL_W-1]}}, uy_reg};
            lbmwb_pkg::REG_INFLOW_VX: prdata = {{(CDW-VEL_W){vx_reg[VEL_W-1]}}, vx_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ux_reg <= '0;
            uy_reg <= '0;
            vx_reg <= '0;
        end
        else
        begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
            vx_reg <= vx_next;
        end
    end

    // ---------------- handshake ----------------
    // a stage loads when it is empty or the stage after it loads
    always_comb
    begin
        en[NSTG] = !vld_reg[NSTG] || m_tready;
        for (int i = NSTG-1; i >= 1; i--)
            en[i] = !vld_reg[i] || en[i+1];
        vld_next[1] = en[1] ? s_tvalid : vld_reg[1];
        for (int i = 2; i <= NSTG; i++)
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
    end

    assign s_tready = en[1];
    assign m_tvalid = vld_reg[NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // ---------------- stage 1: decode, source mux, partial sums ----------------
    always_comb
    begin
        nx_in = s_tdata[1:0];
        ny_in = s_tdata[3:2];
        if (nx_in == lbmwb_pkg::DIR_BAD)
            nx_in = lbmwb_pkg::DIR_M;
        if (ny_in == lbmwb_pkg::DIR_BAD)
            ny_in = lbmwb_pkg::DIR_M;
        for (int i = 0; i < NPOP; i++)
            fin[i] = s_tdata[F_BASE + i*P +: P];

        if (nx_in == lbmwb_pkg::DIR_Z)
        begin
            dir_in[lbmwb_pkg::LANE_A] = {lbmwb_pkg::DIR_M, ny_in};
            dir_in[lbmwb_pkg::LANE_N] = {lbmwb_pkg::DIR_Z, ny_in};
            dir_in[lbmwb_pkg::LANE_B] = {lbmwb_pkg::DIR_P, ny_in};
        end
        else if (ny_in == lbmwb_pkg::DIR_Z)
        begin
            dir_in[lbmwb_pkg::LANE_A] = {nx_in, lbmwb_pkg::DIR_M};
            dir_in[lbmwb_pkg::LANE_N] = {nx_in, lbmwb_pkg::DIR_Z};
            dir_in[lbmwb_pkg::LANE_B] = {nx_in, lbmwb_pkg::DIR_P};
        end
        else
        begin
            dir_in[lbmwb_pkg::LANE_A] = {lbmwb_pkg::DIR_Z, ny_in};
            dir_in[lbmwb_pkg::LANE_N] = {nx_in, ny_in};
            dir_in[lbmwb_pkg::LANE_B] = {nx_in, lbmwb_pkg::DIR_Z};
        end
    end

    always_comb
    begin
        s1_next.cr.op  = lbmwb_pkg::op_t'(s_tuser);
        s1_next.cr.act = (nx_in != lbmwb_pkg::DIR_Z || ny_in != lbmwb_pkg::DIR_Z)
                         && (s_tuser inside {lbmwb_pkg::OP_BOUNCE, lbmwb_pkg::OP_MOVING,
                                             lbmwb_pkg::OP_ZOUHE});
        // axis normal along x: lane B sees east and west already equal
        s1_next.cr.zb   = (ny_in == lbmwb_pkg::DIR_Z);
        s1_next.cr.f    = fin;
        s1_next.cr.diff = (P+1)'(fin[lbmwb_pkg::SLOT_E]) - (P+1)'(fin[lbmwb_pkg::SLOT_W]);
        for (int k = 0; k < NLANE; k++)
        begin
            s1_next.src[k]     = lbmwb_pkg::neg_dir(dir_in[k]);
            s1_next.cr.dst[k]  = lbmwb_pkg::slot_of(dir_in[k]);
            s1_next.cr.v[k]    = fin[lbmwb_pkg::slot_of(lbmwb_pkg::neg_dir(dir_in[k]))];
            s1_next.cr.diag[k] = (dir_in[k].x != lbmwb_pkg::DIR_Z)
                                 && (dir_in[k].y != lbmwb_pkg::DIR_Z);
        end
        s1_next.ra = ACC_W'(fin[lbmwb_pkg::SLOT_E]) + ACC_W'(fin[lbmwb_pkg::SLOT_C])
                     + ACC_W'(fin[lbmwb_pkg::SLOT_W]);
        s1_next.rb = ACC_W'(s1_next.cr.v[0]) + ACC_W'(s1_next.cr.v[1])
                     + ACC_W'(s1_next.cr.v[2]);
    end

    // ---------------- stage 2: density, velocity operand ----------------
    always_comb
    begin
        logic signed [VW-1:0] dot;
        s2_next.cr  = s1_reg.cr;
        s2_next.rho = sat_pop(RSW'(s1_reg.ra) + (RSW'(s1_reg.rb) <<< 1));
        for (int k = 0; k < NLANE; k++)
        begin
            dot = sel_vel(s1_reg.src[k].x, ux_reg) + sel_vel(s1_reg.src[k].y, uy_reg);
            s2_next.m[k] = (s1_reg.cr.op == lbmwb_pkg::OP_MOVING) ? dot : VW'(vx_reg);
        end
    end

    // ---------------- stage 3: rho multiply ----------------
    always_comb
    begin
        s3_next.cr = s2_reg.cr;
        for (int k = 0; k < NLANE; k++)
            s3_next.p[k] = PW'(s2_reg.rho) * PW'(s2_reg.m[k]);
    end

    // ---------------- stage 4: numerators ----------------
    always_comb
    begin
        logic signed [NW-1:0] n1;
        logic [NW-1:0]        n1u;
        logic signed [IW-1:0] dsh;
        s4_next.cr = s3_reg.cr;
        for (int k = 0; k < NLANE; k++)
        begin
            // axis directions carry 2/3 = 4/6, diagonals 1/6
            n1  = s3_reg.cr.diag[k] ? NW'(s3_reg.p[k]) : (NW'(s3_reg.p[k]) <<< 2);
            n1u = n1;
            s4_next.n1neg[k] = n1[NW-1];
            // |n1| plus half the divisor, in one add
            s4_next.n1sum[k] = (n1u ^ {NW{n1[NW-1]}})
                               + (n1[NW-1] ? RND1 + NW'(1) : RND1);
            dsh = (k == lbmwb_pkg::LANE_B && s3_reg.cr.zb) ? '0
                  : (IW'(s3_reg.cr.diff) <<< VFRAC);
            s4_next.inner[k] = (k == lbmwb_pkg::LANE_B) ? IW'(s3_reg.p[k]) - dsh
                                                        : dsh - IW'(s3_reg.p[k]);
        end
    end

    // ---------------- stage 5: scale down and clamp ----------------
    always_comb
    begin
        logic [NW-1:0] xr;
        logic [IW-1:0] iu;
        logic [IW-1:0] m2s;
        logic          neg;
        s5_next.cr    = s4_reg.cr;
        s5_next.n1neg = s4_reg.n1neg;
        for (int k = 0; k < NLANE; k++)
        begin
            xr = s4_reg.n1sum[k] >> (VFRAC + 1);
            // any clamped value still saturates the result
            s5_next.x[k] = (|xr[NW-1:XW]) ? '1 : xr[XW-1:0];
            neg = s4_reg.inner[k][IW-1];
            iu  = s4_reg.inner[k];
            m2s = ((iu ^ {IW{neg}}) + (neg ? RND2 + IW'(1) : RND2)) >> (VFRAC + 1);
            s5_next.m2[k]     = (|m2s[IW-1:MW]) ? '1 : m2s[MW-1:0];
            s5_next.in2neg[k] = neg;
        end
    end

    // ---------------- stage 6: divide by 3, partial products ----------------
    always_comb
    begin
        s6_next.cr     = s5_reg.cr;
        s6_next.n1neg  = s5_reg.n1neg;
        s6_next.m2     = s5_reg.m2;
        s6_next.in2neg = s5_reg.in2neg;
        for (int k = 0; k < NLANE; k++)
        begin
            s6_next.ph[k] = PHW'(s5_reg.x[k][XW-1:HW]) * PHW'(RECIP);
            s6_next.pl[k] = PLW'(s5_reg.x[k][HW-1:0]) * PLW'(RECIP);
        end
    end

    // ---------------- stage 7: quotient, correction select ----------------
    always_comb
    begin
        logic [QW-1:0] qsum;
        s7_next.cr = s6_reg.cr;
        for (int k = 0; k < NLANE; k++)
        begin
            qsum = (QW'(s6_reg.ph[k]) << HW) + QW'(s6_reg.pl[k]);
            case (s6_reg.cr.op)
                lbmwb_pkg::OP_MOVING:
                begin
                    s7_next.mag[k] = qsum[QW-1:RECIP_SH];
                    s7_next.sub[k] = !s6_reg.n1neg[k];
                end
                lbmwb_pkg::OP_ZOUHE:
                begin
                    s7_next.mag[k] = (k == lbmwb_pkg::LANE_N) ? '0 : s6_reg.m2[k];
                    s7_next.sub[k] = s6_reg.in2neg[k];
                end
                default:
                begin
                    s7_next.mag[k] = '0;
                    s7_next.sub[k] = 1'b0;
                end
            endcase
        end
    end

    // ---------------- stage 8: apply, saturate, write back ----------------
    always_comb
    begin
        logic signed [SW-1:0] magx;
        logic signed [SW-1:0] res;
        out_next = s7_reg.cr.f;
        for (int k = 0; k < NLANE; k++)
        begin
            magx = SW'(s7_reg.mag[k]);
            res  = s7_reg.sub[k] ? SW'(s7_reg.cr.v[k]) - magx : SW'(s7_reg.cr.v[k]) + magx;
            if (s7_reg.cr.act)
                out_next[s7_reg.cr.dst[k]] = sat_pop(RSW'(res));
        end
    end

    always_comb
    begin
        m_tdata = '0;
        for (int i = 0; i < NPOP; i++)
            m_tdata[i*P +: P] = out_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            s1_reg <= s1_next;
        if (en[2])
            s2_reg <= s2_next;
        if (en[3])
            s3_reg <= s3_next;
        if (en[4])
            s4_reg <= s4_next;
        if (en[5])
            s5_reg <= s5_next;
        if (en[6])
            s6_reg <= s6_next;
        if (en[7])
            s7_reg <= s7_next;
        if (en[8])
            out_reg <= out_next;
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Stream-level testbench for the D2Q9 wall boundary unit with a cell-by-cell checker.
module testbench;

    localparam int NORM_W          = lbmwb_pkg::NORM_W;
    localparam int NPOP            = lbmwb_pkg::NPOP;
    localparam int NLANE           = lbmwb_pkg::NLANE;
    localparam int OP_W            = lbmwb_pkg::OP_W;
    localparam int VEL_W           = lbmwb_pkg::VEL_W;
    localparam int VEL_FRAC        = lbmwb_pkg::VEL_FRAC;
    localparam int CFG_ADDR_W      = lbmwb_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W      = lbmwb_pkg::CFG_DATA_W;
    localparam int POP_W           = 24;
    localparam int SDATA_W         = ((2*NORM_W + NPOP*POP_W + 7)/8)*8;
    localparam int MDATA_W         = ((NPOP*POP_W + 7)/8)*8;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
    localparam logic [POP_W-1:0] POP_MAX   = 24'h7FFFFF;
    localparam logic [POP_W-1:0] POP_MIN   = 24'h800000;

    typedef logic [NPOP-1:0][POP_W-1:0] pops_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
        pops_t             pop;
    } cell_t;

    class boundary_cell_checker;
        pops_t  expected_pops[$];
        longint ux;
        longint uy;
        longint vx;
        int     mismatches;

        function new();
            ux = 0;
            uy = 0;
            vx = 0;
            mismatches = 0;
        endfunction

        function void set_velocity(lbmwb_pkg::cfg_reg_t r, logic [VEL_W-1:0] v);
            case (r)
                lbmwb_pkg::REG_WALL_UX:   ux = longint'($signed(v));
                lbmwb_pkg::REG_WALL_UY:   uy = longint'($signed(v));
                lbmwb_pkg::REG_INFLOW_VX: vx = longint'($signed(v));
                default:                  ;
            endcase
        endfunction

        static function int pop_index(int x, int y);
            if (y == 0)
                return (x == 0) ? 0 : ((x > 0) ? 1 : 2);
            if (x == 0)
                return (y > 0) ? 3 : 4;
            if (y > 0)
                return (x > 0) ? 5 : 6;
            return (x > 0) ? 7 : 8;
        endfunction

        static function string pop_name(int i);
            case (i)
                0:       return "out_center";
                1:       return "out_east";
                2:       return "out_west";
                3:       return "out_north";
                4:       return "out_south";
                5:       return "out_northeast";
                6:       return "out_northwest";
                7:       return "out_southeast";
                default: return "out_southwest";
            endcase
        endfunction

        static function longint clamp_pop(longint v);
            longint hi;
            hi = (longint'(1) <<< (POP_W-1)) - 1;
            if (v > hi)
                return hi;
            if (v < -hi - 1)
                return -hi - 1;
            return v;
        endfunction

        // round to nearest, ties away from zero
        static function longint round_div(longint num, longint den);
            if (num >= 0)
                return (num + den/2) / den;
            return -((-num + den/2) / den);
        endfunction

        function pops_t correct_cell(cell_t c);
            longint f[NPOP];
            longint rho;
            longint v;
            longint dot;
            longint num;
            longint den;
            longint inner;
            int     ax[3];
            int     ay[3];
            int     nx;
            int     ny;
            int     i;
            int     k;
            bit     diag;
            pops_t  r;
            for (i = 0; i < NPOP; i++)
                f[i] = longint'($signed(c.pop[i]));
            nx = int'($signed(c.nx));
            ny = int'($signed(c.ny));
            if (nx < -1)
                nx = -1;
            if (ny < -1)
                ny = -1;
            if ((nx != 0 || ny != 0) &&
                (c.op == lbmwb_pkg::OP_BOUNCE || c.op == lbmwb_pkg::OP_MOVING ||
                 c.op == lbmwb_pkg::OP_ZOUHE))
            begin
                if (nx == 0)
                begin
                    ax[0] = -1; ay[0] = ny; ax[2] = 1;  ay[2] = ny;
                end
                else if (ny == 0)
                begin
                    ax[0] = nx; ay[0] = -1; ax[2] = nx; ay[2] = 1;
                end
                else
                begin
                    ax[0] = 0;  ay[0] = ny; ax[2] = nx; ay[2] = 0;
                end
                ax[1] = nx;
                ay[1] = ny;
                // density from the incoming cell, before any lane is rewritten
                rho = f[pop_index(-1, 0)] + f[pop_index(0, 0)] + f[pop_index(1, 0)];
                for (k = 0; k < NLANE; k++)
                    rho += 2 * f[pop_index(-ax[k], -ay[k])];
                rho = clamp_pop(rho);
                for (k = 0; k < NLANE; k++)
                begin
                    v = f[pop_index(-ax[k], -ay[k])];
                    if (c.op == lbmwb_pkg::OP_MOVING)
                    begin
                        dot  = -ax[k] * ux - ay[k] * uy;
                        diag = (ax[k] != 0 && ay[k] != 0);
                        num  = diag ? rho * dot : 2 * rho * dot;
                        den  = (diag ? 6 : 3) * (longint'(1) <<< VEL_FRAC);
                        v    = clamp_pop(v - round_div(num, den));
                    end
                    else if (c.op == lbmwb_pkg::OP_ZOUHE && k != lbmwb_pkg::LANE_N)
                    begin
                        // lane writes land in order, so later lanes see them
                        inner = (f[pop_index(1, 0)] - f[pop_index(-1, 0)]) *
                                (longint'(1) <<< VEL_FRAC) - vx * rho;
                        if (k == lbmwb_pkg::LANE_B)
                            inner = -inner;
                        v = clamp_pop(v + round_div(inner, longint'(1) <<< (VEL_FRAC + 1)));
                    end
                    f[pop_index(ax[k], ay[k])] = v;
                end
            end
            for (i = 0; i < NPOP; i++)
                r[i] = f[i][POP_W-1:0];
            return r;
        endfunction

        function void note_cell(cell_t c);
            expected_pops.push_back(correct_cell(c));
        endfunction

        function void check_populations(pops_t got);
            pops_t want;
            int    i;
            if (expected_pops.size() == 0)
            begin
                $display("%0t: result with no cell pending: expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_pops.pop_front();
            for (i = 0; i < NPOP; i++)
            begin
                if (got[i] !== want[i])
                begin
                    $display("%0t: %s expected %h actual %h", $time, pop_name(i),
                             want[i], got[i]);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    // normal_x, normal_y, f_center .. f_southwest, zero pad
    logic [SDATA_W-1:0]    s_tdata;
    // op
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // out_center .. out_southwest
    logic [MDATA_W-1:0]    m_tdata;

    int tx_idle_pct  = 34;
    int rx_idle_pct  = 34;
    bit hold_off_req = 1'b0;

    boundary_cell_checker cells;

    lbm_d2q9_wall_boundary_unit #(
        .POP_WIDTH(POP_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // inputs only change at rising edges, so the falling edge sees what the next edge takes
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && s_tvalid && s_tready === 1'b1)
            cells.note_cell({s_tuser, s_tdata[1:0], s_tdata[3:2], s_tdata[4 +: NPOP*POP_W]});
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready)
            cells.check_populations(m_tdata[NPOP*POP_W-1:0]);
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            m_tready <= (rst_n === 1'b1) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_cell(input cell_t c);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.op;
        s_tdata  <= {{(SDATA_W - 2*NORM_W - NPOP*POP_W){1'b0}}, c.pop, c.ny, c.nx};
        do @(negedge clk); while (s_tready !== 1'b1);
        @(posedge clk);
    endtask

    task automatic write_reg(input lbmwb_pkg::cfg_reg_t r, input logic [VEL_W-1:0] v);
        logic [CFG_DATA_W-1:0] word;
        word = $urandom;
        word[VEL_W-1:0] = v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (pready !== 1'b1);
        @(posedge clk);
        cells.set_velocity(r, v);
        // read back the same register
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (pready !== 1'b1);
        if (prdata[VEL_W-1:0] !== v)
        begin
            $display("%0t: register %s expected %h actual %h", $time, r.name(), v,
                     prdata[VEL_W-1:0]);
            cells.mismatches++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_velocities(input logic [VEL_W-1:0] ux, input logic [VEL_W-1:0] uy,
                                  input logic [VEL_W-1:0] vx);
        write_reg(lbmwb_pkg::REG_WALL_UX, ux);
        write_reg(lbmwb_pkg::REG_WALL_UY, uy);
        write_reg(lbmwb_pkg::REG_INFLOW_VX, vx);
    endtask

    task automatic drain_cells();
        s_tvalid <= 1'b0;
        while (cells.expected_pops.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [NORM_W-1:0] pick_dir();
        case ($urandom_range(2))
            0:       return lbmwb_pkg::DIR_M;
            1:       return lbmwb_pkg::DIR_Z;
            default: return lbmwb_pkg::DIR_P;
        endcase
    endfunction

    // populations near rest: 4/9, 1/9 and 1/36 of unit density, with jitter
    function automatic pops_t rest_pops(int salt);
        pops_t p;
        int    i;
        for (i = 0; i < NPOP; i++)
        begin
            p[i] = (i == 0) ? 24'h071C72 : ((i < 5) ? 24'h01C71C : 24'h0071C7);
            p[i] = p[i] + POP_W'(salt * (i + 1) * 'h135);
        end
        return p;
    endfunction

    function automatic pops_t uniform_pops(logic [POP_W-1:0] v);
        pops_t p;
        int    i;
        for (i = 0; i < NPOP; i++)
            p[i] = v;
        return p;
    endfunction

    function automatic cell_t random_cell();
        cell_t c;
        int    i;
        int    mode;
        c.op = ($urandom_range(19) == 0) ? OP_UNUSED : OP_W'($urandom_range(2));
        if ($urandom_range(99) < 85)
        begin
            do
            begin
                c.nx = pick_dir();
                c.ny = pick_dir();
            end
            while (c.nx == lbmwb_pkg::DIR_Z && c.ny == lbmwb_pkg::DIR_Z);
        end
        else
        begin
            c.nx = NORM_W'($urandom);
            c.ny = NORM_W'($urandom);
        end
        mode = $urandom_range(9);
        for (i = 0; i < NPOP; i++)
        begin
            if (mode < 6)
                c.pop[i] = POP_W'($urandom_range('h60000));
            else if (mode < 8)
                c.pop[i] = POP_W'($urandom);
            else if (mode == 8)
            begin
                case ($urandom_range(3))
                    0:       c.pop[i] = POP_MAX;
                    1:       c.pop[i] = POP_MIN;
                    2:       c.pop[i] = '0;
                    default: c.pop[i] = POP_W'($urandom);
                endcase
            end
            else
                c.pop[i] = ($urandom_range(8) == 0) ? POP_W'($urandom) :
                           POP_W'($urandom_range('h30000)) - POP_W'('h8000);
        end
        return c;
    endfunction

    task automatic run_random(input int n);
        repeat (n) send_cell(random_cell());
    endtask

    task automatic run_directed();
        logic [NORM_W-1:0] nxs [8] = '{lbmwb_pkg::DIR_P, lbmwb_pkg::DIR_M, lbmwb_pkg::DIR_Z,
                                       lbmwb_pkg::DIR_Z, lbmwb_pkg::DIR_P, lbmwb_pkg::DIR_M,
                                       lbmwb_pkg::DIR_P, lbmwb_pkg::DIR_M};
        logic [NORM_W-1:0] nys [8] = '{lbmwb_pkg::DIR_Z, lbmwb_pkg::DIR_Z, lbmwb_pkg::DIR_P,
                                       lbmwb_pkg::DIR_M, lbmwb_pkg::DIR_P, lbmwb_pkg::DIR_P,
                                       lbmwb_pkg::DIR_M, lbmwb_pkg::DIR_M};
        logic [OP_W-1:0]   ops [3] = '{lbmwb_pkg::OP_BOUNCE, lbmwb_pkg::OP_MOVING,
                                       lbmwb_pkg::OP_ZOUHE};
        pops_t             alt;
        int                i;
        for (i = 0; i < NPOP; i++)
            alt[i] = i[0] ? POP_MIN : POP_MAX;
        // every axis and corner normal
        for (i = 0; i < 8; i++)
            send_cell(cell_t'{ops[i % 3], nxs[i], nys[i], rest_pops(i + 1)});
        send_cell(cell_t'{OP_UNUSED, lbmwb_pkg::DIR_Z, lbmwb_pkg::DIR_P, rest_pops(9)});
        send_cell(cell_t'{lbmwb_pkg::OP_MOVING, lbmwb_pkg::DIR_Z, lbmwb_pkg::DIR_Z,
                          rest_pops(10)});
        // out-of-range normal component pattern acts as -1
        send_cell(cell_t'{lbmwb_pkg::OP_BOUNCE, lbmwb_pkg::DIR_BAD, lbmwb_pkg::DIR_Z,
                          rest_pops(11)});
        send_cell(cell_t'{lbmwb_pkg::OP_ZOUHE, lbmwb_pkg::DIR_Z, lbmwb_pkg::DIR_BAD,
                          rest_pops(12)});
        send_cell(cell_t'{lbmwb_pkg::OP_BOUNCE, lbmwb_pkg::DIR_BAD, lbmwb_pkg::DIR_BAD,
                          rest_pops(13)});
        // density and corrections driven into saturation
        send_cell(cell_t'{lbmwb_pkg::OP_MOVING, lbmwb_pkg::DIR_Z, lbmwb_pkg::DIR_M,
                          uniform_pops(POP_MAX)});
        send_cell(cell_t'{lbmwb_pkg::OP_ZOUHE, lbmwb_pkg::DIR_M, lbmwb_pkg::DIR_Z,
                          uniform_pops(POP_MIN)});
        send_cell(cell_t'{lbmwb_pkg::OP_MOVING, lbmwb_pkg::DIR_P, lbmwb_pkg::DIR_P, alt});
        send_cell(cell_t'{lbmwb_pkg::OP_ZOUHE, lbmwb_pkg::DIR_P, lbmwb_pkg::DIR_Z,
                          uniform_pops('0)});
        send_cell(cell_t'{lbmwb_pkg::OP_ZOUHE, lbmwb_pkg::DIR_M, lbmwb_pkg::DIR_M,
                          uniform_pops(POP_MAX)});
        send_cell(cell_t'{lbmwb_pkg::OP_MOVING, lbmwb_pkg::DIR_M, lbmwb_pkg::DIR_Z, ~alt});
    endtask

    initial
    begin
        cells = new();
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // velocities still at their reset values
        run_random(100);
        drain_cells();

        set_velocities(24'h019999, 24'hFF3333, 24'h00A3D7);
        run_directed();
        run_random(200);
        drain_cells();

        // result side holds off while cells keep coming, so the pipeline backs up
        set_velocities(POP_MAX, POP_MAX, POP_MAX);
        hold_off_req = 1'b1;
        tx_idle_pct = 0;
        run_random(40);
        tx_idle_pct = 34;
        run_random(200);
        drain_cells();

        // stretch with no idling on either side
        set_velocities(POP_MIN, POP_MIN, POP_MIN);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(200);
        tx_idle_pct = 34;
        rx_idle_pct = 34;
        run_random(100);
        drain_cells();

        set_velocities('0, POP_MAX, POP_MIN);
        run_random(200);
        drain_cells();

        repeat (3)
        begin
            set_velocities(VEL_W'($urandom), VEL_W'($urandom), VEL_W'($urandom));
            run_random(150);
            drain_cells();
        end

        if (cells.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
design/lbmwb_pkg.sv
design/lbm_d2q9_wall_boundary_unit.sv
bench/testbench.sv
